FILE: rtl/point_in_capsule_test_macros.svh
// Assertion macros shared by the point-in-capsule checker.
`ifndef POINT_IN_CAPSULE_TEST_MACROS_SVH
`define POINT_IN_CAPSULE_TEST_MACROS_SVH

// Implication or plain property, sampled on the rising edge, off during reset.
`define PCAP_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define PCAP_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

FILE: rtl/pcap_pkg.sv
// Package with widths, codes and types of the point-in-capsule test.
package pcap_pkg;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned RAD_W      = 15;
  localparam int unsigned R_W        = RAD_W + 1;
  localparam int unsigned RR_W       = 2 * R_W;
  localparam int unsigned DIFF_W     = COORD_W + 1;
  localparam int unsigned SQ_W       = 2 * DIFF_W;
  localparam int unsigned DOT_W      = SQ_W + 1;
  localparam int unsigned HALF_W     = SQ_W / 2;
  localparam int unsigned PROD_W     = 2 * SQ_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = COORD_W;
  localparam int unsigned REGION_W   = 2;
  localparam int unsigned FRONT_LAT  = 4;
  localparam int unsigned MUL_LAT    = 2;
  localparam int unsigned PIPE_LAT   = FRONT_LAT + MUL_LAT + 1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_END_A_X = 3'd0,
    CFG_END_A_Y = 3'd1,
    CFG_END_A_Z = 3'd2,
    CFG_END_B_X = 3'd3,
    CFG_END_B_Y = 3'd4,
    CFG_END_B_Z = 3'd5,
    CFG_RADIUS  = 3'd6,
    CFG_MARGIN  = 3'd7
  } cfg_idx_e;

  typedef enum logic [REGION_W-1:0] {
    REGION_BALL = 2'd0,
    REGION_END  = 2'd1,
    REGION_SIDE = 2'd2
  } region_e;

  typedef struct packed {
    coord_t             end_a_x;
    coord_t             end_a_y;
    coord_t             end_a_z;
    coord_t             end_b_x;
    coord_t             end_b_y;
    coord_t             end_b_z;
    logic [RAD_W-1:0]   radius;
    logic [RAD_W-1:0]   margin;
  } cfg_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic ball;
    logic beyond;
    logic near_a;
    logic near_b;
  } ctl_t;

endpackage

FILE: rtl/pcap_cfg.sv
// Capsule configuration register file.
module pcap_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pcap_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pcap_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output pcap_pkg::cfg_t                   cfg_o
);
  import pcap_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_END_A_X: cfg_d.end_a_x = cfg_data_i;
        CFG_END_A_Y: cfg_d.end_a_y = cfg_data_i;
        CFG_END_A_Z: cfg_d.end_a_z = cfg_data_i;
        CFG_END_B_X: cfg_d.end_b_x = cfg_data_i;
        CFG_END_B_Y: cfg_d.end_b_y = cfg_data_i;
        CFG_END_B_Z: cfg_d.end_b_z = cfg_data_i;
        CFG_RADIUS:  cfg_d.radius  = cfg_data_i[RAD_W-1:0];
        CFG_MARGIN:  cfg_d.margin  = cfg_data_i[RAD_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/pcap_front.sv
// Front pipeline: differences, squares, sums and region compares.
module pcap_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  pcap_pkg::coord_t              point_x_i,
  input  pcap_pkg::coord_t              point_y_i,
  input  pcap_pkg::coord_t              point_z_i,
  input  logic                          last_point_i,
  input  pcap_pkg::cfg_t                cfg_i,
  output pcap_pkg::ctl_t                ctl_o,
  output logic [pcap_pkg::SQ_W-1:0]     diff_o,
  output logic [pcap_pkg::SQ_W-1:0]     h2_o,
  output logic [pcap_pkg::SQ_W-1:0]     tmag_o
);
  import pcap_pkg::*;

  function automatic logic signed [SQ_W-1:0] smul(input logic signed [DIFF_W-1:0] x,
                                                  input logic signed [DIFF_W-1:0] y);
    smul = SQ_W'(x) * SQ_W'(y);
  endfunction

  coord_t p [3];
  coord_t a [3];
  coord_t b [3];

  assign p[0] = point_x_i;
  assign p[1] = point_y_i;
  assign p[2] = point_z_i;
  assign a[0] = cfg_i.end_a_x;
  assign a[1] = cfg_i.end_a_y;
  assign a[2] = cfg_i.end_a_z;
  assign b[0] = cfg_i.end_b_x;
  assign b[1] = cfg_i.end_b_y;
  assign b[2] = cfg_i.end_b_z;

  logic [FRONT_LAT-1:0] valid_q;
  logic [FRONT_LAT-1:0] last_q;

  // stage 1
  logic signed [DIFF_W-1:0] pa_q [3];
  logic signed [DIFF_W-1:0] pb_q [3];
  logic signed [DIFF_W-1:0] d_q  [3];
  logic        [R_W-1:0]    r_q;

  // stage 2
  logic        [SQ_W-1:0]   pa_sq_q [3];
  logic        [SQ_W-1:0]   pb_sq_q [3];
  logic        [SQ_W-1:0]   d_sq_q  [3];
  logic signed [SQ_W-1:0]   pd_q    [3];
  logic        [RR_W-1:0]   rr2_q;
  logic                     ball2_q;

  // stage 3
  logic        [SQ_W-1:0]   paq_q;
  logic        [SQ_W-1:0]   pbq_q;
  logic        [SQ_W-1:0]   h2_3_q;
  logic signed [DOT_W-1:0]  t_q;
  logic        [RR_W-1:0]   rr3_q;
  logic                     ball3_q;

  // stage 4
  ctl_t                     ctl_q;
  logic        [SQ_W-1:0]   diff_q;
  logic        [SQ_W-1:0]   h2_4_q;
  logic        [SQ_W-1:0]   tmag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[FRONT_LAT-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= {last_q[FRONT_LAT-2:0], last_point_i};
    for (int i = 0; i < 3; i++) begin
      pa_q[i] <= DIFF_W'(p[i]) - DIFF_W'(a[i]);
      pb_q[i] <= DIFF_W'(p[i]) - DIFF_W'(b[i]);
      d_q[i]  <= DIFF_W'(b[i]) - DIFF_W'(a[i]);
    end
    r_q <= R_W'(cfg_i.radius) + R_W'(cfg_i.margin);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      pa_sq_q[i] <= smul(pa_q[i], pa_q[i]);
      pb_sq_q[i] <= smul(pb_q[i], pb_q[i]);
      d_sq_q[i]  <= smul(d_q[i], d_q[i]);
      pd_q[i]    <= smul(pa_q[i], d_q[i]);
    end
    rr2_q   <= RR_W'(r_q) * RR_W'(r_q);
    ball2_q <= (d_q[0] == '0) && (d_q[1] == '0) && (d_q[2] == '0);
  end

  always_ff @(posedge clk_i) begin
    paq_q   <= pa_sq_q[0] + pa_sq_q[1] + pa_sq_q[2];
    pbq_q   <= pb_sq_q[0] + pb_sq_q[1] + pb_sq_q[2];
    h2_3_q  <= d_sq_q[0] + d_sq_q[1] + d_sq_q[2];
    t_q     <= DOT_W'(pd_q[0]) + DOT_W'(pd_q[1]) + DOT_W'(pd_q[2]);
    rr3_q   <= rr2_q;
    ball3_q <= ball2_q;
  end

  always_ff @(posedge clk_i) begin
    ctl_q.valid  <= 1'b0;
    ctl_q.last   <= last_q[FRONT_LAT-2];
    ctl_q.ball   <= ball3_q;
    ctl_q.beyond <= t_q[DOT_W-1] || (t_q > $signed({1'b0, h2_3_q}));
    ctl_q.near_a <= paq_q <= SQ_W'(rr3_q);
    ctl_q.near_b <= pbq_q <= SQ_W'(rr3_q);
    diff_q       <= paq_q - SQ_W'(rr3_q);
    h2_4_q       <= h2_3_q;
    tmag_q       <= t_q[SQ_W-1:0];
  end

  always_comb begin
    ctl_o       = ctl_q;
    ctl_o.valid = valid_q[FRONT_LAT-1];
  end

  assign diff_o = diff_q;
  assign h2_o   = h2_4_q;
  assign tmag_o = tmag_q;

endmodule

FILE: rtl/pcap_mul.sv
// Two-stage split multiplier for the wide side-of-segment products.
module pcap_mul (
  input  logic                          clk_i,
  input  logic [pcap_pkg::SQ_W-1:0]     a_i,
  input  logic [pcap_pkg::SQ_W-1:0]     b_i,
  output logic [pcap_pkg::PROD_W-1:0]   p_o
);
  import pcap_pkg::*;

  logic [HALF_W-1:0] a_lo, a_hi, b_lo, b_hi;
  logic [SQ_W-1:0]   ll_q, lh_q, hl_q, hh_q;
  logic [PROD_W-1:0] p_q;

  assign a_lo = a_i[HALF_W-1:0];
  assign a_hi = a_i[SQ_W-1:HALF_W];
  assign b_lo = b_i[HALF_W-1:0];
  assign b_hi = b_i[SQ_W-1:HALF_W];

  always_ff @(posedge clk_i) begin
    ll_q <= SQ_W'(a_lo) * SQ_W'(b_lo);
    lh_q <= SQ_W'(a_lo) * SQ_W'(b_hi);
    hl_q <= SQ_W'(a_hi) * SQ_W'(b_lo);
    hh_q <= SQ_W'(a_hi) * SQ_W'(b_hi);
  end

  always_ff @(posedge clk_i) begin
    p_q <= (PROD_W'(hh_q) << SQ_W) + (PROD_W'(lh_q) << HALF_W)
         + (PROD_W'(hl_q) << HALF_W) + PROD_W'(ll_q);
  end

  assign p_o = p_q;

endmodule

FILE: rtl/point_in_capsule_test.sv
// Point-in-capsule test, top level.
// Throughput: one point per cycle; busy stays low, results cannot be held off.
// Depth is set by the split 34x34 multipliers (two stages) behind four front stages.
// Reset clears the pipeline valid bits and sets every capsule register to zero.
module point_in_capsule_test (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [pcap_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pcap_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [15:0]               point_x_i,
  input  logic signed [15:0]               point_y_i,
  input  logic signed [15:0]               point_z_i,
  input  logic                             last_point_i,
  output logic                             done_o,
  output logic                             hit_o,
  output logic [1:0]                       region_o,
  output logic                             last_result_o
);
  import pcap_pkg::*;

  cfg_t              cfg;
  ctl_t              front_ctl;
  logic [SQ_W-1:0]   diff, h2, tmag;
  logic [PROD_W-1:0] prod_d, prod_t;
  ctl_t              ctl_q [MUL_LAT];
  ctl_t              c;

  logic    done_q;
  logic    hit_q;
  region_e region_q;
  logic    last_q;

  assign busy = 1'b0;

  pcap_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  pcap_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (start && !busy),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .last_point_i (last_point_i),
    .cfg_i        (cfg),
    .ctl_o        (front_ctl),
    .diff_o       (diff),
    .h2_o         (h2),
    .tmag_o       (tmag)
  );

  pcap_mul u_mul_dist (
    .clk_i (clk_i),
    .a_i   (diff),
    .b_i   (h2),
    .p_o   (prod_d)
  );

  pcap_mul u_mul_dot (
    .clk_i (clk_i),
    .a_i   (tmag),
    .b_i   (tmag),
    .p_o   (prod_t)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MUL_LAT; i++) begin
        ctl_q[i] <= '0;
      end
    end else begin
      ctl_q[0] <= front_ctl;
      for (int i = 1; i < MUL_LAT; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  assign c = ctl_q[MUL_LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= c.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    last_q <= c.last;
    if (c.ball) begin
      region_q <= REGION_BALL;
      hit_q    <= c.near_a;
    end else if (c.beyond) begin
      region_q <= REGION_END;
      hit_q    <= c.near_a || c.near_b;
    end else begin
      region_q <= REGION_SIDE;
      hit_q    <= c.near_a || (prod_d <= prod_t);
    end
  end

  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign region_o      = region_q;
  assign last_result_o = last_q;

endmodule

FILE: rtl/pcap_checker.sv
// Port-level checker for the point-in-capsule test and its bind.
`include "point_in_capsule_test_macros.svh"

module pcap_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic last_point_i,
  input logic last_result_o
);
  import pcap_pkg::*;

  `PCAP_NEVER(a_busy_low, clk_i, rst_ni, busy, "busy raised")
  `PCAP_ASSERT(a_result_follows, clk_i, rst_ni, start && !busy |-> ##PIPE_LAT done_o, "transfer lost")
  `PCAP_ASSERT(a_result_caused, clk_i, rst_ni, done_o |-> $past(start && !busy, PIPE_LAT), "result invented")
  `PCAP_ASSERT(a_last_echo, clk_i, rst_ni, done_o |-> last_result_o == $past(last_point_i, PIPE_LAT), "last marker mismatch")

endmodule

bind point_in_capsule_test pcap_checker u_pcap_checker (.*);
